// ----- src/rhsl_pkg.sv -----
// shared constants and types for the rgb to hsl pixel converter
// no dependencies; used by rhsl_divider and rgb_to_hsl_pixel
package rhsl_pkg;

    localparam int CHAN_W     = 8;
    localparam int DATA_W     = 3 * CHAN_W;
    localparam int SUM_W      = CHAN_W + 1;
    localparam int QUO_W      = 8;
    localparam int NUM_W      = 2 * QUO_W;
    localparam int DIV_STAGES = 4;
    localparam int DIV_STEPS  = QUO_W / DIV_STAGES;
    localparam int N_STAGES   = DIV_STAGES + 3;
    localparam int LIGHT_W    = 20;

    localparam logic [CHAN_W-1:0]  CHAN_MAX    = 8'd255;
    localparam logic [CHAN_W-1:0]  HSL_SCALE   = 8'd240;
    localparam logic [CHAN_W-1:0]  HUE_SIXTH   = 8'd40;
    localparam logic [CHAN_W-1:0]  HUE_GREEN   = 8'd80;
    localparam logic [CHAN_W-1:0]  HUE_BLUE    = 8'd160;
    localparam logic [SUM_W-1:0]   SUM_MID     = 9'd255;
    localparam logic [SUM_W-1:0]   SUM_TOP     = 9'd510;
    // 8/17 scaled by 4096, exact floor for sums up to 510
    localparam logic [LIGHT_W-1:0] LIGHT_RECIP = 20'd1928;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

    // per-stage load enables of the divider pipeline
    typedef struct packed {
        logic [DIV_STAGES-1:0] load;
    } t_div_ctl;

endpackage

// ----- src/rhsl_divider.sv -----
// pipelined restoring divider, 16 by 8 bits with 8-bit quotient
// two quotient bits per stage; depends on rhsl_pkg
module rhsl_divider (
    input  logic                          i_clk,
    input  rhsl_pkg::t_div_ctl            i_ctl,
    input  logic [rhsl_pkg::NUM_W-1:0]    i_num,
    input  logic [rhsl_pkg::QUO_W-1:0]    i_den,
    output logic [rhsl_pkg::QUO_W-1:0]    o_quo,
    output logic                          o_rem_nz
);
    import rhsl_pkg::*;

    typedef struct packed {
        logic [QUO_W-1:0] rem;
        logic [QUO_W-1:0] low;
        logic [QUO_W-1:0] quo;
    } t_div_st;

    t_div_st          r_st  [DIV_STAGES];
    logic [QUO_W-1:0] r_den [DIV_STAGES];
    t_div_st          n_st  [DIV_STAGES];

    function automatic t_div_st div_steps(input t_div_st s, input logic [QUO_W-1:0] den);
        t_div_st        w;
        logic [QUO_W:0] t;
        w = s;
        for (int i = 0; i < DIV_STEPS; i++) begin
            t     = {w.rem, w.low[QUO_W-1]};
            w.low = {w.low[QUO_W-2:0], 1'b0};
            if (t >= {1'b0, den}) begin
                w.rem = QUO_W'(t - {1'b0, den});
                w.quo = {w.quo[QUO_W-2:0], 1'b1};
            end else begin
                w.rem = t[QUO_W-1:0];
                w.quo = {w.quo[QUO_W-2:0], 1'b0};
            end
        end
        return w;
    endfunction

    always_comb begin
        t_div_st init;
        init.rem = i_num[NUM_W-1:QUO_W];
        init.low = i_num[QUO_W-1:0];
        init.quo = '0;
        n_st[0] = div_steps(init, i_den);
        for (int k = 1; k < DIV_STAGES; k++) begin
            n_st[k] = div_steps(r_st[k-1], r_den[k-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[0]) begin
            r_st[0]  <= n_st[0];
            r_den[0] <= i_den;
        end
        for (int k = 1; k < DIV_STAGES; k++) begin
            if (i_ctl.load[k]) begin
                r_st[k]  <= n_st[k];
                r_den[k] <= r_den[k-1];
            end
        end
    end

    assign o_quo    = r_st[DIV_STAGES-1].quo;
    assign o_rem_nz = |r_st[DIV_STAGES-1].rem;

endmodule

// ----- src/rgb_to_hsl_pixel.sv -----
// rgb to hsl pixel converter, 0..240 scale; throughput one item per cycle while the output
// is ready, set by the seven-stage pipeline with two divider bits per stage
// each stage advances when it is empty or the stage after it moves, so bubbles close up
// reset (i_rst_n low at a clock edge) clears all stage valid bits; data registers are not reset
// depends on rhsl_pkg and rhsl_divider
module rgb_to_hsl_pixel (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    // red_in [7:0], green_in [15:8], blue_in [23:16]
    input  logic [rhsl_pkg::DATA_W-1:0]  i_s_axis_tdata,
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    // hue_out [7:0], saturation_out [15:8], lightness_out [23:16]
    output logic [rhsl_pkg::DATA_W-1:0]  o_m_axis_tdata
);
    import rhsl_pkg::*;

    // stage map: 0 max/min, 1 products and divisor, 2..5 dividers, 6 output register
    localparam int LAST = N_STAGES - 1;

    logic [N_STAGES-1:0] r_v;
    logic [N_STAGES:0]   en;

    // stage enable chain from the output side back to the input
    always_comb begin
        en[N_STAGES] = i_m_axis_tready;
        for (int k = N_STAGES - 1; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_s_axis_tready = en[0];
    assign o_m_axis_tvalid = r_v[LAST];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < N_STAGES; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // ---------------- stage 0: channel max, min and sector ----------------
    logic [CHAN_W-1:0] red, green, blue;
    logic [CHAN_W-1:0] hi, lo, dif_a, dif_b;
    t_sector           sec;

    assign red   = i_s_axis_tdata[CHAN_W-1:0];
    assign green = i_s_axis_tdata[2*CHAN_W-1:CHAN_W];
    assign blue  = i_s_axis_tdata[3*CHAN_W-1:2*CHAN_W];

    always_comb begin
        // ties go to red, then green
        if (red >= green && red >= blue) begin
            sec = SEC_RED;
        end else if (green >= blue) begin
            sec = SEC_GREEN;
        end else begin
            sec = SEC_BLUE;
        end
        lo = red;
        if (green < lo) lo = green;
        if (blue < lo)  lo = blue;
        case (sec)
            SEC_RED: begin
                hi    = red;
                dif_a = green;
                dif_b = blue;
            end
            SEC_GREEN: begin
                hi    = green;
                dif_a = blue;
                dif_b = red;
            end
            SEC_BLUE: begin
                hi    = blue;
                dif_a = red;
                dif_b = green;
            end
            default: begin
                hi    = red;
                dif_a = green;
                dif_b = blue;
            end
        endcase
    end

    logic [CHAN_W-1:0] r_c0, r_d0;
    logic [SUM_W-1:0]  r_sum0;
    t_sector           r_sec0;
    logic              r_neg0;

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_c0   <= hi - lo;
            r_sum0 <= SUM_W'(hi) + SUM_W'(lo);
            r_sec0 <= sec;
            r_neg0 <= dif_a < dif_b;
            r_d0   <= (dif_a < dif_b) ? (dif_b - dif_a) : (dif_a - dif_b);
        end
    end

    // ---------------- stage 1: numerators, divisor, lightness ----------------
    logic [LIGHT_W-1:0] light_prod;
    logic [SUM_W-1:0]   sat_den_w;

    assign light_prod = LIGHT_W'(r_sum0) * LIGHT_RECIP;
    // 255 - |sum - 255|, never above 255
    assign sat_den_w  = (r_sum0 >= SUM_MID) ? (SUM_TOP - r_sum0) : r_sum0;

    logic [NUM_W-1:0]  r_sat_num1, r_hue_num1;
    logic [QUO_W-1:0]  r_sat_den1, r_hue_den1;
    logic [CHAN_W-1:0] r_light [1:LAST-1];
    t_sector           r_sec   [1:LAST-1];
    logic              r_neg   [1:LAST-1];
    logic              r_grey  [1:LAST-1];

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_sat_num1 <= NUM_W'(r_c0) * NUM_W'(HSL_SCALE);
            r_hue_num1 <= NUM_W'(r_d0) * NUM_W'(HUE_SIXTH);
            r_sat_den1 <= sat_den_w[QUO_W-1:0];
            r_hue_den1 <= r_c0;
            r_light[1] <= light_prod[LIGHT_W-1:LIGHT_W-CHAN_W];
            r_sec[1]   <= r_sec0;
            r_neg[1]   <= r_neg0;
            // zero chroma also covers the zero saturation divisor
            r_grey[1]  <= (r_c0 == '0);
        end
        for (int k = 2; k < LAST; k++) begin
            if (en[k]) begin
                r_light[k] <= r_light[k-1];
                r_sec[k]   <= r_sec[k-1];
                r_neg[k]   <= r_neg[k-1];
                r_grey[k]  <= r_grey[k-1];
            end
        end
    end

    // ---------------- stages 2..5: saturation and hue dividers ----------------
    t_div_ctl          div_ctl;
    logic [QUO_W-1:0]  sat_quo, hue_quo;
    logic              sat_rem_nz, hue_rem_nz;

    assign div_ctl.load = en[LAST-1:2];

    rhsl_divider u_sat_div (
        .i_clk    (i_clk),
        .i_ctl    (div_ctl),
        .i_num    (r_sat_num1),
        .i_den    (r_sat_den1),
        .o_quo    (sat_quo),
        .o_rem_nz (sat_rem_nz)
    );

    rhsl_divider u_hue_div (
        .i_clk    (i_clk),
        .i_ctl    (div_ctl),
        .i_num    (r_hue_num1),
        .i_den    (r_hue_den1),
        .o_quo    (hue_quo),
        .o_rem_nz (hue_rem_nz)
    );

    // ---------------- stage 6: hue assembly and output register ----------------
    logic [CHAN_W-1:0] hue_base, hue, sat;

    always_comb begin
        case (r_sec[LAST-1])
            SEC_RED:   hue_base = r_neg[LAST-1] ? HSL_SCALE : '0;
            SEC_GREEN: hue_base = HUE_GREEN;
            SEC_BLUE:  hue_base = HUE_BLUE;
            default:   hue_base = '0;
        endcase
        // a negative difference takes the ceiling of the quotient off the base
        if (r_neg[LAST-1]) begin
            hue = hue_base - hue_quo - CHAN_W'(hue_rem_nz);
        end else begin
            hue = hue_base + hue_quo;
        end
        sat = sat_quo;
        // grey pixel: hue and saturation are zero
        if (r_grey[LAST-1]) begin
            hue = '0;
            sat = '0;
        end
    end

    logic [DATA_W-1:0] r_out;

    always_ff @(posedge i_clk) begin
        if (en[LAST]) begin
            r_out <= {r_light[LAST-1], sat, hue};
        end
    end

    assign o_m_axis_tdata = r_out;

    // sat_rem_nz is not needed for a floor
    logic unused_rem;
    assign unused_rem = sat_rem_nz;

`ifndef NO_ASSERTIONS
    // an accepted item is in the first stage at the next edge
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> r_v[0])
        else $error("accepted item missing from stage 0");

    // input stalls only when every stage is full
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (&r_v))
        else $error("input stalled with an empty stage");

    // results stay within their ranges
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[7:0] < HSL_SCALE
            && o_m_axis_tdata[15:8] <= HSL_SCALE && o_m_axis_tdata[23:16] <= HSL_SCALE))
        else $error("result field out of range");
`endif

endmodule
